>>> rtl/core/mfb_pkg.sv
`default_nettype none
package mfb_pkg;

  // fixed field widths
  localparam int NODE_W   = 3;
  localparam int CAP_W    = 16;
  localparam int FLOW_W   = 19;
  localparam int NCNT_W   = 4;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam int NODES_DEF    = 8;
  localparam int CAP_BITS_DEF = 16;

  localparam logic [FLOW_W-1:0] FLOW_MAX = {FLOW_W{1'b1}};

  // register indexes
  localparam logic [1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [1:0] REG_SOURCE     = 2'd1;
  localparam logic [1:0] REG_SINK       = 2'd2;

  localparam logic [NCNT_W-1:0] NODE_COUNT_RST = 4'd8;
  localparam logic [NODE_W-1:0] SOURCE_RST     = 3'd0;
  localparam logic [NODE_W-1:0] SINK_RST       = 3'd7;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_CLEAR,
    DP_LOAD,
    DP_START,
    DP_BFS_INIT,
    DP_POP,
    DP_POP_LATCH,
    DP_SCAN_RD,
    DP_SCAN_CHK,
    DP_WALK_INIT,
    DP_UPD_INIT,
    DP_PAR_RD,
    DP_EDGE_RD,
    DP_BN_CHK,
    DP_UP_FWD,
    DP_UP_REV,
    DP_ADD_FLOW,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic trivial;
    logic q_empty;
    logic scan_end;
    logic hit_sink;
    logic walk_end;
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/mfb_in_if.sv
`default_nettype none
interface mfb_in_if;
  import mfb_pkg::*;
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] from_node;
  logic [NODE_W-1:0] to_node;
  logic [CAP_W-1:0]  capacity;
  logic              last;

  modport source (output valid, from_node, to_node, capacity, last, input ready);
  modport sink   (input valid, from_node, to_node, capacity, last, output ready);
endinterface
`default_nettype wire

>>> rtl/core/mfb_out_if.sv
`default_nettype none
interface mfb_out_if;
  import mfb_pkg::*;
  logic              valid;
  logic              ready;
  logic [FLOW_W-1:0] max_flow;

  modport source (output valid, max_flow, input ready);
  modport sink   (input valid, max_flow, output ready);
endinterface
`default_nettype wire

>>> rtl/core/max_flow_bfs_augment.sv
// Edmonds-Karp max flow over a NODES x NODES capacity matrix. Matrix entries are taken one
// word per cycle while the block is idle; the word with last set starts the solve. Each
// augmenting round runs a breadth-first search that reads and checks each matrix entry of
// each dequeued node, then two walks along the parent path, one for the bottleneck (read
// parent, read edge, compare) and one for the update (read parent, read edge, write the
// forward and the reverse residual), all bound by the single read port of the residual
// memory. After each result, and after reset, the residual memory is cleared one entry
// per cycle over all its entries, during which no input word is taken; configuration
// writes are taken at any time but must only change while the block is idle.
`default_nettype none
module max_flow_bfs_augment #(
  parameter int NODES    = mfb_pkg::NODES_DEF,
  parameter int CAP_BITS = mfb_pkg::CAP_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  mfb_in_if.sink                            in_ch,
  mfb_out_if.source                         out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mfb_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [mfb_pkg::PDATA_W-1:0]  pwdata,
  output logic      [mfb_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready
);
  import mfb_pkg::*;

  logic [NCNT_W-1:0] node_count_r;
  logic [NODE_W-1:0] source_node_r, sink_node_r;
  logic [1:0]        reg_idx;
  logic              cfg_wr;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r  <= NODE_COUNT_RST;
      source_node_r <= SOURCE_RST;
      sink_node_r   <= SINK_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_NODE_COUNT: node_count_r  <= pwdata[NCNT_W-1:0];
        REG_SOURCE:     source_node_r <= pwdata[NODE_W-1:0];
        REG_SINK:       sink_node_r   <= pwdata[NODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_NODE_COUNT: prdata = PDATA_W'(node_count_r);
      REG_SOURCE:     prdata = PDATA_W'(source_node_r);
      REG_SINK:       prdata = PDATA_W'(sink_node_r);
      default:        prdata = '0;
    endcase
  end

  mfb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mfb_dp #(
    .NODES    (NODES),
    .CAP_BITS (CAP_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .from_node   (in_ch.from_node),
    .to_node     (in_ch.to_node),
    .capacity    (in_ch.capacity),
    .node_count  (node_count_r),
    .source_node (source_node_r),
    .sink_node   (sink_node_r),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .max_flow    (out_ch.max_flow)
  );

endmodule
`default_nettype wire

>>> rtl/core/mfb_dp.sv
`default_nettype none
module mfb_dp #(
  parameter int NODES    = mfb_pkg::NODES_DEF,
  parameter int CAP_BITS = mfb_pkg::CAP_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire mfb_pkg::dp_cmd_t            cmd,
  output mfb_pkg::dp_stat_t                stat,
  input  wire logic [mfb_pkg::NODE_W-1:0]  from_node,
  input  wire logic [mfb_pkg::NODE_W-1:0]  to_node,
  input  wire logic [mfb_pkg::CAP_W-1:0]   capacity,
  input  wire logic [mfb_pkg::NCNT_W-1:0]  node_count,
  input  wire logic [mfb_pkg::NODE_W-1:0]  source_node,
  input  wire logic [mfb_pkg::NODE_W-1:0]  sink_node,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [mfb_pkg::FLOW_W-1:0]       max_flow
);
  import mfb_pkg::*;

  localparam int NW  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CW  = $clog2(NODES + 1);
  localparam int AW  = 2 * NW;
  localparam int RD  = 1 << AW;
  localparam int RW  = CAP_BITS + 1;
  localparam int SW  = ((RW > FLOW_W) ? RW : FLOW_W) + 1;
  localparam int RSW = RW + 1;
  localparam logic [RW-1:0]    RES_MAX = {RW{1'b1}};
  localparam logic [CAP_W-1:0] CAP_MASK16 =
    (CAP_BITS >= CAP_W) ? {CAP_W{1'b1}} : CAP_W'((64'd1 << CAP_BITS) - 64'd1);

  // residual, parent and queue stores
  logic [RW-1:0] res_mem [RD];
  logic          res_we;
  logic [AW-1:0] res_wa, res_ra;
  logic [RW-1:0] res_wd, res_rd_r;

  logic [NW-1:0] par_mem [NODES];
  logic          par_we;
  logic [NW-1:0] par_wa, par_ra, par_wd, par_rd_r;

  logic [NW-1:0] q_mem [NODES];
  logic          q_we;
  logic [NW-1:0] q_wa, q_ra, q_wd, q_rd_r;

  logic [CW-1:0]     n_r, n_nxt, v_r, v_nxt, head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0]     steps_r, steps_nxt;
  logic [NW-1:0]     u_r, u_nxt, w_r, w_nxt, pu_r, pu_nxt;
  logic [RW-1:0]     bn_r, bn_nxt;
  logic [FLOW_W-1:0] flow_r, flow_nxt, max_flow_r, max_flow_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [NODES-1:0]  visited_r, visited_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [CW-1:0]  n_eff;
  logic [NW-1:0]  src_i, dst_i, v_i;
  logic           take;
  logic [SW-1:0]  flow_sum;
  logic [RSW-1:0] rev_sum;
  logic [RW-1:0]  rev_wd;
  logic           row_ok;

  always_comb begin
    n_eff = (8'(node_count) > 8'(NODES)) ? CW'(NODES) : CW'(node_count);
    src_i = NW'(source_node);
    dst_i = NW'(sink_node);
    v_i   = v_r[NW-1:0];
    take  = !visited_r[v_i] && (res_rd_r != '0);
    row_ok = (8'(from_node) < 8'(NODES)) && (8'(to_node) < 8'(NODES));
    flow_sum = SW'(flow_r) + SW'(bn_r);
    rev_sum  = RSW'(res_rd_r) + RSW'(bn_r);
    rev_wd   = (rev_sum > RSW'(RES_MAX)) ? RES_MAX : rev_sum[RW-1:0];

    stat.clr_done = (clr_r == {AW{1'b1}});
    stat.trivial  = (source_node == sink_node) || (8'(source_node) >= 8'(n_eff)) ||
                    (8'(sink_node) >= 8'(n_eff));
    stat.q_empty  = (head_r == tail_r);
    stat.scan_end = (v_r == n_r);
    stat.hit_sink = take && (v_i == dst_i);
    stat.walk_end = (w_r == src_i) || (steps_r == CW'(NODES));
    stat.out_busy = out_valid_r;
  end

  always_comb begin
    res_we = 1'b0; res_wa = '0; res_wd = '0; res_ra = '0;
    par_we = 1'b0; par_wa = '0; par_wd = '0; par_ra = '0;
    q_we   = 1'b0; q_wa   = '0; q_wd   = '0; q_ra   = '0;
    n_nxt = n_r; v_nxt = v_r; head_nxt = head_r; tail_nxt = tail_r;
    steps_nxt = steps_r; u_nxt = u_r; w_nxt = w_r; pu_nxt = pu_r;
    bn_nxt = bn_r; flow_nxt = flow_r; clr_nxt = clr_r; visited_nxt = visited_r;
    max_flow_nxt = max_flow_r;
    out_valid_nxt = (out_valid_r && out_ready) ? 1'b0 : out_valid_r;
    case (cmd.op)
      DP_CLEAR: begin
        res_we  = 1'b1;
        res_wa  = clr_r;
        clr_nxt = clr_r + 1'b1;
      end
      DP_LOAD: begin
        res_we = row_ok;
        res_wa = {NW'(from_node), NW'(to_node)};
        res_wd = RW'(capacity & CAP_MASK16);
      end
      DP_START: begin
        n_nxt    = n_eff;
        flow_nxt = '0;
      end
      DP_BFS_INIT: begin
        visited_nxt        = '0;
        visited_nxt[src_i] = 1'b1;
        q_we     = 1'b1;
        q_wa     = '0;
        q_wd     = src_i;
        head_nxt = '0;
        tail_nxt = CW'(1);
      end
      DP_POP: begin
        q_ra     = head_r[NW-1:0];
        head_nxt = head_r + 1'b1;
      end
      DP_POP_LATCH: begin
        u_nxt = q_rd_r;
        v_nxt = '0;
      end
      DP_SCAN_RD: res_ra = {u_r, v_i};
      DP_SCAN_CHK: begin
        if (take) begin
          par_we = 1'b1;
          par_wa = v_i;
          par_wd = u_r;
          visited_nxt[v_i] = 1'b1;
          if (!stat.hit_sink && (tail_r < CW'(NODES))) begin
            q_we     = 1'b1;
            q_wa     = tail_r[NW-1:0];
            q_wd     = v_i;
            tail_nxt = tail_r + 1'b1;
          end
        end
        v_nxt = v_r + 1'b1;
      end
      DP_WALK_INIT: begin
        w_nxt     = dst_i;
        steps_nxt = '0;
        bn_nxt    = RES_MAX;
      end
      DP_UPD_INIT: begin
        w_nxt     = dst_i;
        steps_nxt = '0;
      end
      DP_PAR_RD: par_ra = w_r;
      DP_EDGE_RD: begin
        pu_nxt = par_rd_r;
        res_ra = {par_rd_r, w_r};
      end
      DP_BN_CHK: begin
        if (res_rd_r < bn_r) bn_nxt = res_rd_r;
        w_nxt     = pu_r;
        steps_nxt = steps_r + 1'b1;
      end
      DP_UP_FWD: begin
        res_we = 1'b1;
        res_wa = {pu_r, w_r};
        res_wd = res_rd_r - bn_r;
        res_ra = {w_r, pu_r};
      end
      DP_UP_REV: begin
        res_we    = 1'b1;
        res_wa    = {w_r, pu_r};
        res_wd    = rev_wd;
        w_nxt     = pu_r;
        steps_nxt = steps_r + 1'b1;
      end
      DP_ADD_FLOW: begin
        flow_nxt = (flow_sum > SW'(FLOW_MAX)) ? FLOW_MAX : flow_sum[FLOW_W-1:0];
      end
      DP_EMIT: begin
        out_valid_nxt = 1'b1;
        max_flow_nxt  = flow_r;
        clr_nxt       = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (res_we) res_mem[res_wa] <= res_wd;
    res_rd_r <= res_mem[res_ra];
  end

  always_ff @(posedge clk) begin
    if (par_we) par_mem[par_wa] <= par_wd;
    par_rd_r <= par_mem[par_ra];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    q_rd_r <= q_mem[q_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      flow_r      <= '0;
      bn_r        <= '0;
      head_r      <= '0;
      tail_r      <= '0;
    end else begin
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      flow_r      <= flow_nxt;
      bn_r        <= bn_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    v_r        <= v_nxt;
    steps_r    <= steps_nxt;
    u_r        <= u_nxt;
    w_r        <= w_nxt;
    pu_r       <= pu_nxt;
    visited_r  <= visited_nxt;
    max_flow_r <= max_flow_nxt;
  end

  assign out_valid = out_valid_r;
  assign max_flow  = max_flow_r;

  a_src_visited: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_SCAN_CHK) |-> visited_r[src_i])
    else $error("source not marked visited during scan");

  a_queue_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_POP) |-> (head_r < tail_r) && (tail_r <= CW'(NODES)))
    else $error("queue pointers out of order");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_EMIT) |=> out_valid_r && (max_flow_r == $past(flow_r)))
    else $error("result not presented after emit");

  a_bn_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_UP_FWD) |-> (bn_r != '0))
    else $error("zero bottleneck on augmenting path");

endmodule
`default_nettype wire

>>> rtl/core/mfb_ctrl.sv
`default_nettype none
module mfb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_last,
  output logic                   in_ready,
  input  wire mfb_pkg::dp_stat_t stat,
  output mfb_pkg::dp_cmd_t       cmd
);
  import mfb_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_START, S_BFS_INIT, S_POP, S_POP_LATCH, S_SCAN_RD, S_SCAN_CHK,
    S_BN_INIT, S_BN_PAR, S_BN_EDGE, S_BN_CHK, S_UP_INIT, S_UP_PAR, S_UP_EDGE,
    S_UP_FWD, S_UP_REV, S_ADD, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = DP_NOP;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.op = DP_CLEAR;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = DP_LOAD;
          if (in_last) state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.op    = DP_START;
        state_nxt = stat.trivial ? S_DONE : S_BFS_INIT;
      end
      S_BFS_INIT: begin
        cmd.op    = DP_BFS_INIT;
        state_nxt = S_POP;
      end
      S_POP: begin
        if (stat.q_empty) begin
          state_nxt = S_DONE;
        end else begin
          cmd.op    = DP_POP;
          state_nxt = S_POP_LATCH;
        end
      end
      S_POP_LATCH: begin
        cmd.op    = DP_POP_LATCH;
        state_nxt = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        if (stat.scan_end) begin
          state_nxt = S_POP;
        end else begin
          cmd.op    = DP_SCAN_RD;
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        cmd.op    = DP_SCAN_CHK;
        state_nxt = stat.hit_sink ? S_BN_INIT : S_SCAN_RD;
      end
      S_BN_INIT: begin
        cmd.op    = DP_WALK_INIT;
        state_nxt = S_BN_PAR;
      end
      S_BN_PAR: begin
        if (stat.walk_end) begin
          state_nxt = S_UP_INIT;
        end else begin
          cmd.op    = DP_PAR_RD;
          state_nxt = S_BN_EDGE;
        end
      end
      S_BN_EDGE: begin
        cmd.op    = DP_EDGE_RD;
        state_nxt = S_BN_CHK;
      end
      S_BN_CHK: begin
        cmd.op    = DP_BN_CHK;
        state_nxt = S_BN_PAR;
      end
      S_UP_INIT: begin
        cmd.op    = DP_UPD_INIT;
        state_nxt = S_UP_PAR;
      end
      S_UP_PAR: begin
        if (stat.walk_end) begin
          state_nxt = S_ADD;
        end else begin
          cmd.op    = DP_PAR_RD;
          state_nxt = S_UP_EDGE;
        end
      end
      S_UP_EDGE: begin
        cmd.op    = DP_EDGE_RD;
        state_nxt = S_UP_FWD;
      end
      S_UP_FWD: begin
        cmd.op    = DP_UP_FWD;
        state_nxt = S_UP_REV;
      end
      S_UP_REV: begin
        cmd.op    = DP_UP_REV;
        state_nxt = S_UP_PAR;
      end
      S_ADD: begin
        cmd.op    = DP_ADD_FLOW;
        state_nxt = S_BFS_INIT;
      end
      S_DONE: begin
        // wait for the previous word to leave the output register
        if (!stat.out_busy) begin
          cmd.op    = DP_EMIT;
          state_nxt = S_CLEAR;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire
